// ===== rtl/lbs_pkg.sv =====
package lbs_pkg;

    localparam int MAX_BONES_DEF  = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORDS_PER_BONE = 12;
    localparam int TRANS_SLOT     = 9;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_INFL = 1'b1;

    localparam logic [1:0] KIND_POS  = 2'd0;
    localparam logic [1:0] KIND_NORM = 2'd1;
    localparam logic [1:0] KIND_TAN  = 2'd2;
    localparam logic [1:0] KIND_RSV  = 2'd3;

    typedef struct packed {
        logic               command;
        logic [5:0]         bone_id;
        logic [3:0]         slot;
        logic signed [31:0] load_value;
        logic [16:0]        weight;
        logic [1:0]         vec_kind;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic               last_influence;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic       latch;
        logic       rd_mat;
        logic       rd_trn;
        logic       mul;
        logic       add_term;
        logic       trn_add;
        logic       wmul;
        logic       acc_upd;
        logic       load_a;
        logic       pos_out;
        logic       zero_out;
        logic       scale;
        logic       sq;
        logic       sq_add;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       emit;
        logic [1:0] row;
        logic [1:0] col;
    } t_cmd;

    typedef struct packed {
        logic bone_ok;
        logic is_last;
        logic kind_pos;
        logic a_zero;
        logic scaled;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/lbs_ctrl.sv =====
module lbs_ctrl import lbs_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_is_load,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int DIV_W = 30 + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CHECK = 5'd1;
    localparam logic [4:0] ST_RD    = 5'd2;
    localparam logic [4:0] ST_MUL   = 5'd3;
    localparam logic [4:0] ST_ADD   = 5'd4;
    localparam logic [4:0] ST_TRD   = 5'd5;
    localparam logic [4:0] ST_TADD  = 5'd6;
    localparam logic [4:0] ST_WMUL  = 5'd7;
    localparam logic [4:0] ST_ACC   = 5'd8;
    localparam logic [4:0] ST_LAST  = 5'd9;
    localparam logic [4:0] ST_KIND  = 5'd10;
    localparam logic [4:0] ST_SCALE = 5'd11;
    localparam logic [4:0] ST_SQ    = 5'd12;
    localparam logic [4:0] ST_SQA   = 5'd13;
    localparam logic [4:0] ST_RTI   = 5'd14;
    localparam logic [4:0] ST_SQRT  = 5'd15;
    localparam logic [4:0] ST_DINIT = 5'd16;
    localparam logic [4:0] ST_DIV   = 5'd17;
    localparam logic [4:0] ST_DSTO  = 5'd18;
    localparam logic [4:0] ST_EMIT  = 5'd19;

    logic [4:0]       r_state, n_state;
    logic [1:0]       r_row, n_row;
    logic [1:0]       r_col, n_col;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_cmd.row = r_row;
        o_cmd.col = r_col;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (!i_in_is_load) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                n_row = '0;
                n_col = '0;
                n_state = i_sts.bone_ok ? ST_RD : ST_LAST;
            end
            ST_RD: begin
                o_cmd.rd_mat = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add_term = 1'b1;
                if (r_col == 2'd2) begin
                    n_col = '0;
                    n_state = ST_TRD;
                end else begin
                    n_col = r_col + 2'd1;
                    n_state = ST_RD;
                end
            end
            ST_TRD: begin
                o_cmd.rd_trn = 1'b1;
                n_state = ST_TADD;
            end
            ST_TADD: begin
                o_cmd.trn_add = 1'b1;
                n_state = ST_WMUL;
            end
            ST_WMUL: begin
                o_cmd.wmul = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_upd = 1'b1;
                if (r_row == 2'd2) begin
                    n_row = '0;
                    n_state = ST_LAST;
                end else begin
                    n_row = r_row + 2'd1;
                    n_state = ST_RD;
                end
            end
            ST_LAST: begin
                if (i_sts.is_last) begin
                    o_cmd.load_a = 1'b1;
                    n_state = ST_KIND;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_KIND: begin
                n_col = '0;
                if (i_sts.kind_pos) begin
                    o_cmd.pos_out = 1'b1;
                    n_state = ST_EMIT;
                end else if (i_sts.a_zero) begin
                    o_cmd.zero_out = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                if (i_sts.scaled) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state = ST_SQA;
            end
            ST_SQA: begin
                o_cmd.sq_add = 1'b1;
                if (r_col == 2'd2) begin
                    n_col = '0;
                    n_state = ST_RTI;
                end else begin
                    n_col = r_col + 2'd1;
                    n_state = ST_SQ;
                end
            end
            ST_RTI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(31)) begin
                    n_state = ST_DINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = ST_DSTO;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DSTO: begin
                o_cmd.div_store = 1'b1;
                if (r_col == 2'd2) begin
                    n_col = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_col = r_col + 2'd1;
                    n_state = ST_DINIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lbs_dp.sv =====
module lbs_dp import lbs_pkg::*; #(
    parameter int MAX_BONES = MAX_BONES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int DEPTH  = MAX_BONES * WORDS_PER_BONE;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CALC_W = (AW > 10) ? AW : 10;
    localparam int DIV_W  = 30 + FRAC_BITS;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    logic [5:0]          r_bone;
    logic [1:0]          r_kind;
    logic [16:0]         r_weight;
    logic signed [31:0]  r_v [3];
    logic                r_last;
    logic signed [63:0]  r_prod;
    logic signed [63:0]  r_t;
    logic signed [31:0]  r_tc;
    logic signed [49:0]  r_wprod;
    logic signed [47:0]  r_acc [3];
    logic signed [47:0]  r_a [3];
    logic signed [31:0]  r_res [3];
    logic                r_ovf;
    logic [61:0]         r_sqp;
    logic [63:0]         r_len2;
    logic [63:0]         r_n;
    logic [63:0]         r_r;
    logic [63:0]         r_bit;
    logic [DIV_W-1:0]    r_dvd;
    logic [DIV_W-1:0]    r_q;
    logic [31:0]         r_rem;
    logic                r_neg;
    logic                r_out_valid;
    t_out_item           r_out;

    // table addressing
    logic [CALC_W-1:0] wr_addr, rd_base, rd_addr, row3;
    logic              load_ok;

    assign wr_addr = CALC_W'({i_in_data.bone_id, 3'b000}) + CALC_W'({i_in_data.bone_id, 2'b00})
                   + CALC_W'(i_in_data.slot);
    assign load_ok = (32'(i_in_data.bone_id) < MAX_BONES)
                   && (32'(i_in_data.slot) < WORDS_PER_BONE);
    assign rd_base = CALC_W'({r_bone, 3'b000}) + CALC_W'({r_bone, 2'b00});
    assign row3    = CALC_W'({i_cmd.row, 1'b0}) + CALC_W'(i_cmd.row);
    assign rd_addr = i_cmd.rd_trn
                   ? rd_base + CALC_W'(TRANS_SLOT) + CALC_W'(i_cmd.row)
                   : rd_base + row3 + CALC_W'(i_cmd.col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch && i_in_data.command == CMD_LOAD && load_ok) begin
            r_mem[wr_addr[AW-1:0]] <= i_in_data.load_value;
        end
        if (i_cmd.rd_mat || i_cmd.rd_trn) begin
            r_rdata <= r_mem[rd_addr[AW-1:0]];
        end
    end

    // selections by lane
    logic signed [31:0] v_sel;
    logic signed [47:0] acc_sel, a_sel;

    always_comb begin
        case (i_cmd.col)
            2'd0:    v_sel = r_v[0];
            2'd1:    v_sel = r_v[1];
            default: v_sel = r_v[2];
        endcase
        case (i_cmd.col)
            2'd0:    a_sel = r_a[0];
            2'd1:    a_sel = r_a[1];
            default: a_sel = r_a[2];
        endcase
        case (i_cmd.row)
            2'd0:    acc_sel = r_acc[0];
            2'd1:    acc_sel = r_acc[1];
            default: acc_sel = r_acc[2];
        endcase
    end

    // matrix and weight arithmetic
    logic signed [63:0] mul_p, term, tsum;
    logic signed [49:0] wmul_p, winc;
    logic signed [50:0] acc_sum;
    logic               t_sat, acc_sat;
    logic signed [31:0] t_clamp;
    logic signed [47:0] acc_clamp;

    assign mul_p  = r_rdata * v_sel;
    assign term   = r_prod >>> FRAC_BITS;
    assign tsum   = r_t + ((r_kind == KIND_POS) ? 64'(r_rdata) : 64'sd0);
    assign t_sat  = !((&tsum[63:31]) || !(|tsum[63:31]));
    assign t_clamp = t_sat ? (tsum[63] ? 32'sh8000_0000 : 32'sh7fff_ffff) : tsum[31:0];
    assign wmul_p = r_tc * $signed({1'b0, r_weight});
    assign winc   = r_wprod >>> FRAC_BITS;
    assign acc_sum = 51'(acc_sel) + 51'(winc);
    assign acc_sat = !((&acc_sum[50:47]) || !(|acc_sum[50:47]));
    assign acc_clamp = acc_sat
                     ? (acc_sum[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                     : acc_sum[47:0];

    // position output clamp
    logic signed [31:0] pos_v [3];
    logic [2:0]         pos_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_sat[i] = !((&r_acc[i][47:31]) || !(|r_acc[i][47:31]));
            pos_v[i]   = pos_sat[i] ? (r_acc[i][47] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                    : r_acc[i][31:0];
        end
    end

    // normalisation support
    logic [47:0] mag [3];
    logic [47:0] m01, m_max;
    logic signed [30:0] a31;
    logic signed [61:0] sq_p;
    logic [63:0] rb;
    logic [32:0] rem_sh;
    logic [31:0] len;
    logic [29:0] a_mag;
    logic        qbit;
    logic [31:0] q32;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_a[i][47] ? 48'(-r_a[i]) : 48'(r_a[i]);
        end
    end

    assign m01    = (mag[1] > mag[0]) ? mag[1] : mag[0];
    assign m_max  = (mag[2] > m01) ? mag[2] : m01;
    assign a31    = a_sel[30:0];
    assign sq_p   = a31 * a31;
    assign rb     = r_r + r_bit;
    assign len    = r_r[31:0];
    assign rem_sh = {r_rem, r_dvd[DIV_W-1]};
    assign qbit   = (rem_sh >= {1'b0, len});
    assign a_mag  = a_sel[47] ? 30'(-a_sel) : 30'(a_sel);
    assign q32    = r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_bone   <= i_in_data.bone_id;
            r_kind   <= (i_in_data.vec_kind == KIND_RSV) ? KIND_TAN : i_in_data.vec_kind;
            r_weight <= i_in_data.weight;
            r_v[0]   <= i_in_data.vec_x;
            r_v[1]   <= i_in_data.vec_y;
            r_v[2]   <= i_in_data.vec_z;
            r_last   <= i_in_data.last_influence;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.add_term) begin
            r_t <= (i_cmd.col == 2'd0) ? term : r_t + term;
        end
        if (i_cmd.trn_add) begin
            r_tc <= t_clamp;
        end
        if (i_cmd.wmul) begin
            r_wprod <= wmul_p;
        end
        if (i_cmd.load_a) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= r_acc[i];
            end
        end
        if (i_cmd.scale && !(m_max[47:30] == '0 && m_max[29])) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= (|m_max[47:30]) ? (r_a[i] >>> 1) : (r_a[i] <<< 1);
            end
        end
        if (i_cmd.pos_out) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= pos_v[i];
            end
        end
        if (i_cmd.zero_out) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= '0;
            end
        end
        if (i_cmd.sq) begin
            r_sqp <= sq_p[61:0];
        end
        if (i_cmd.sq_add) begin
            r_len2 <= (i_cmd.col == 2'd0) ? 64'(r_sqp) : r_len2 + 64'(r_sqp);
        end
        if (i_cmd.sqrt_init) begin
            r_n   <= r_len2;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end
        if (i_cmd.sqrt_step) begin
            if (r_n >= rb) begin
                r_n <= r_n - rb;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_dvd <= {a_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_q   <= '0;
            r_neg <= a_sel[47];
        end
        if (i_cmd.div_step) begin
            r_rem <= qbit ? 32'(rem_sh - {1'b0, len}) : rem_sh[31:0];
            r_dvd <= r_dvd << 1;
            r_q   <= {r_q[DIV_W-2:0], qbit};
        end
        if (i_cmd.div_store) begin
            case (i_cmd.col)
                2'd0:    r_res[0] <= r_neg ? -q32 : q32;
                2'd1:    r_res[1] <= r_neg ? -q32 : q32;
                default: r_res[2] <= r_neg ? -q32 : q32;
            endcase
        end
        if (i_cmd.emit) begin
            r_out.out_kind  <= r_kind;
            r_out.out_x     <= r_res[0];
            r_out.out_y     <= r_res[1];
            r_out.out_z     <= r_res[2];
            r_out.saturated <= r_ovf;
        end
    end

    // accumulator, saturation flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= '0;
            end
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                for (int i = 0; i < 3; i++) begin
                    r_acc[i] <= '0;
                end
                r_ovf <= 1'b0;
            end else begin
                if (i_cmd.acc_upd) begin
                    case (i_cmd.row)
                        2'd0:    r_acc[0] <= acc_clamp;
                        2'd1:    r_acc[1] <= acc_clamp;
                        default: r_acc[2] <= acc_clamp;
                    endcase
                end
                if ((i_cmd.trn_add && t_sat) || (i_cmd.acc_upd && acc_sat)
                    || (i_cmd.pos_out && |pos_sat)) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.bone_ok  = (32'(r_bone) < MAX_BONES);
    assign o_sts.is_last  = r_last;
    assign o_sts.kind_pos = (r_kind == KIND_POS);
    assign o_sts.a_zero   = (m_max == '0);
    assign o_sts.scaled   = (m_max[47:30] == '0) && m_max[29];
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/linear_blend_skinning_core.sv =====
// Linear blend skinning engine, signed fixed point with FRAC_BITS fraction bits. A load
// transaction writes one word of a bone's 3x3 matrix or translation into a
// single-port table of MAX_BONES*12 words; reading a never-loaded word gives undefined data.
// An influence transaction uses a 32x32 multiplier for the nine matrix terms and a 32x18
// multiplier for the three weight products, one table read per step. On the last
// influence of a position the accumulators are clamped and emitted; on the last
// influence of a normal or tangent, normalisation picks the path, rescales by
// powers of two (up to 29 steps), sums the squared length, takes a bit-serial square
// root, runs three bit-serial divides (one per component) and emits. One transaction
// is worked at a time; a finished result waits in the output register while the next
// transaction is taken.
module linear_blend_skinning_core import lbs_pkg::*; #(
    parameter int MAX_BONES = MAX_BONES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cmd cmd;
    t_sts sts;

    lbs_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_is_load (i_in_data.command == CMD_LOAD),
        .o_in_ready   (o_in_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    lbs_dp #(
        .MAX_BONES (MAX_BONES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/lbs_checker.sv =====
module lbs_checker import lbs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // an accepted influence makes the engine busy and drops ready
    a_busy_after_infl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command == CMD_INFL |=> !o_in_ready)
        else $error("ready while influence in flight");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.out_kind != KIND_RSV)
        else $error("reserved kind on output");

endmodule

bind linear_blend_skinning_core lbs_checker u_lbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/linear_blend_skinning_core_tb.sv =====
`timescale 1ns / 100ps

module linear_blend_skinning_core_tb;
    import lbs_pkg::*;

    localparam int  BONES     = MAX_BONES_DEF;
    localparam int  FRAC      = FRAC_BITS_DEF;
    localparam int  IDLE_MAX  = 20000;
    localparam int  PAUSE_AT  = 400;
    localparam int  HOLD_AT   = 60;
    localparam int  HOLD_LEN  = 2500;
    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint W_HI   = 64'sh7FFF_FFFF;
    localparam longint W_LO   = -W_HI - 1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    linear_blend_skinning_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #10 i_clk = ~i_clk;

    t_in_item  pending_items[$];
    t_out_item skinned_q[$];

    // predictor state
    int     bone_words[BONES*WORDS_PER_BONE];
    longint blend_acc[3];
    bit     clamp_seen;
    // generator view of which table words hold data
    bit     word_loaded[BONES*WORDS_PER_BONE];

    int  mismatches = 0;
    int  sent = 0;
    int  results_seen = 0;
    bit  in_taken = 1'b0;
    bit  stim_done = 1'b0;
    int  idle_cycles = 0;

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        if (x > hi) begin
            clamp_seen = 1'b1;
            return hi;
        end
        if (x < lo) begin
            clamp_seen = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned peak_mag(longint a[3]);
        longint unsigned m;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            if ((a[i] < 0 ? -a[i] : a[i]) > m) m = a[i] < 0 ? -a[i] : a[i];
        end
        return m;
    endfunction

    task automatic skin_step(input t_in_item it);
        longint v[3];
        longint a[3];
        longint t;
        longint unsigned m;
        longint unsigned len2;
        longint unsigned len;
        logic [1:0] kind;
        t_out_item r;
        int base;
        if (it.command == CMD_LOAD) begin
            if (it.bone_id < BONES && it.slot < WORDS_PER_BONE)
                bone_words[it.bone_id*WORDS_PER_BONE + it.slot] = it.load_value;
            return;
        end
        kind = (it.vec_kind == KIND_RSV) ? KIND_TAN : it.vec_kind;
        v[0] = it.vec_x;
        v[1] = it.vec_y;
        v[2] = it.vec_z;
        if (it.bone_id < BONES) begin
            base = it.bone_id * WORDS_PER_BONE;
            for (int i = 0; i < 3; i++) begin
                t = 0;
                for (int j = 0; j < 3; j++)
                    t += (longint'(bone_words[base + 3*i + j]) * v[j]) >>> FRAC;
                if (kind == KIND_POS) t += longint'(bone_words[base + TRANS_SLOT + i]);
                t = clamp_to(t, W_LO, W_HI);
                blend_acc[i] = clamp_to(blend_acc[i] + ((t * longint'(it.weight)) >>> FRAC),
                                        ACC_LO, ACC_HI);
            end
        end
        if (!it.last_influence) return;
        if (kind == KIND_POS) begin
            for (int i = 0; i < 3; i++) a[i] = clamp_to(blend_acc[i], W_LO, W_HI);
        end else begin
            a = blend_acc;
            m = peak_mag(a);
            if (m != 0) begin
                while (m >= (64'd1 << 30)) begin
                    for (int i = 0; i < 3; i++) a[i] = a[i] >>> 1;
                    m = peak_mag(a);
                end
                while (m < (64'd1 << 29)) begin
                    for (int i = 0; i < 3; i++) a[i] = a[i] * 2;
                    m = m * 2;
                end
                len2 = 0;
                for (int i = 0; i < 3; i++) len2 += longint'(a[i] * a[i]);
                len = int_sqrt(len2);
                for (int i = 0; i < 3; i++) a[i] = (a[i] * (64'sd1 <<< FRAC)) / longint'(len);
            end
        end
        r.out_kind  = kind;
        r.out_x     = a[0][31:0];
        r.out_y     = a[1][31:0];
        r.out_z     = a[2][31:0];
        r.saturated = clamp_seen;
        skinned_q.insert(skinned_q.size(), r);
        blend_acc = '{0, 0, 0};
        clamp_seen = 1'b0;
    endtask

    // stimulus helpers
    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return 0;
            default: return $signed($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return 17'($urandom);
            1: return 17'h10000;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic add_load(input int bone, input int slot, input logic signed [31:0] val);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.command = CMD_LOAD;
        it.bone_id = 6'(bone);
        it.slot = 4'(slot);
        it.load_value = val;
        if (bone < BONES && slot < WORDS_PER_BONE)
            word_loaded[bone*WORDS_PER_BONE + slot] = 1'b1;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic add_infl(input int bone, input logic [16:0] w, input logic [1:0] kind,
                            input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input bit last);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.command = CMD_INFL;
        it.bone_id = 6'(bone);
        it.weight = w;
        it.vec_kind = kind;
        it.vec_x = x;
        it.vec_y = y;
        it.vec_z = z;
        it.last_influence = last;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic bit bone_full(int b);
        for (int s = 0; s < WORDS_PER_BONE; s++)
            if (!word_loaded[b*WORDS_PER_BONE + s]) return 0;
        return 1;
    endfunction

    function automatic int pick_bone();
        int b;
        do b = $urandom_range(0, BONES-1); while (!bone_full(b));
        return b;
    endfunction

    // driver
    int in_gap = 0;
    always @(negedge i_clk) begin
        logic     nv;
        t_in_item nd;
        nv = i_in_valid;
        nd = i_in_data;
        if (in_taken) begin
            in_taken = 1'b0;
            nv = 1'b0;
        end
        if (i_rst_n && !nv) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_items.size() != 0 &&
                         !(sent == PAUSE_AT && skinned_q.size() != 0)) begin
                nd = pending_items.pop_front();
                nv = 1'b1;
                sent++;
                case ($urandom_range(0, 19))
                    0: in_gap = $urandom_range(20, 300);
                    1, 2, 3, 4, 5: in_gap = $urandom_range(1, 4);
                    default: in_gap = 0;
                endcase
                // stretches of back-to-back transactions
                if ((sent / 100) % 3 == 1) in_gap = 0;
            end
        end
        i_in_valid <= nv;
        i_in_data <= nd;
    end

    // receiver side ready
    int out_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            case ($urandom_range(0, 19))
                0: out_gap = $urandom_range(30, 400);
                1, 2, 3, 4: out_gap = $urandom_range(1, 5);
                default: out_gap = 0;
            endcase
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_out_item exp_r;
        bit any;
        any = 1'b0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            any = 1'b1;
            results_seen++;
            if (skinned_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                exp_r = skinned_q.pop_front();
                if (o_out_data.out_kind !== exp_r.out_kind || o_out_data.out_x !== exp_r.out_x ||
                    o_out_data.out_y !== exp_r.out_y || o_out_data.out_z !== exp_r.out_z ||
                    o_out_data.saturated !== exp_r.saturated) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("result %0d mismatch: exp kind=%0d x=%0d y=%0d z=%0d sat=%0d, ",
                               results_seen, exp_r.out_kind, exp_r.out_x, exp_r.out_y,
                               exp_r.out_z, exp_r.saturated);
                        $display("got kind=%0d x=%0d y=%0d z=%0d sat=%0d",
                                 o_out_data.out_kind, o_out_data.out_x, o_out_data.out_y,
                                 o_out_data.out_z, o_out_data.saturated);
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            any = 1'b1;
            in_taken = 1'b1;
            skin_step(i_in_data);
        end
        idle_cycles = any ? 0 : idle_cycles + 1;
        if (idle_cycles > IDLE_MAX) begin
            $display("linear_blend_skinning_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int n;
        int b;
        logic [1:0] k;
        blend_acc = '{0, 0, 0};
        clamp_seen = 1'b0;

        // table setup: identity, full-scale extremes, and six random bones
        for (int s = 0; s < WORDS_PER_BONE; s++)
            add_load(0, s, (s == 0 || s == 4 || s == 8) ? 32'sh10000 :
                           (s >= TRANS_SLOT ? 32'sh30000 : 32'sh0));
        for (int s = 0; s < WORDS_PER_BONE; s++)
            add_load(1, s, s[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        for (int bb = 2; bb < 8; bb++)
            for (int s = 0; s < WORDS_PER_BONE; s++) add_load(bb, s, rand_q());

        // directed
        add_load(2, 13, 32'sh1234_5678);
        add_infl(0, 17'h10000, KIND_POS, 32'sh10000, -32'sh20000, 32'sh7FFF_FFFF, 1);
        add_infl(0, 17'h10000, KIND_NORM, 32'sh10000, 32'sh10000, 0, 1);
        add_infl(0, 17'h10000, KIND_TAN, -32'sh30000, 32'sh40000, 0, 1);
        add_infl(0, 17'h10000, KIND_RSV, 0, 32'sh1, 32'sh8000_0000, 1);
        add_infl(0, 17'h10000, KIND_NORM, 0, 0, 0, 1);
        add_infl(1, 17'h1FFFF, KIND_POS, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
        add_infl(1, 17'h1FFFF, KIND_NORM, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1);
        add_infl(0, 17'h0, KIND_POS, 32'sh10000, 32'sh10000, 32'sh10000, 1);
        add_infl(0, 17'h8000, KIND_NORM, 32'sh10000, 0, 0, 0);
        add_infl(2, 17'h8000, KIND_POS, 32'sh10000, 32'sh10000, 0, 0);
        add_infl(3, 17'h8000, KIND_TAN, 0, 32'sh10000, 32'sh10000, 1);
        for (int i = 0; i < 6; i++)
            add_infl(1, 17'h1FFFF, KIND_POS, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     i == 5);

        // random: mostly whole vertices, some loads and some oddly formed sequences
        while (pending_items.size() < 1250) begin
            case ($urandom_range(0, 9))
                0: add_load($urandom_range(0, BONES-1), $urandom_range(0, 15), rand_q());
                1: add_infl(pick_bone(), rand_weight(), 2'($urandom), rand_q(), rand_q(),
                            rand_q(), $urandom_range(0, 1));
                default: begin
                    n = $urandom_range(1, 4);
                    k = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 2));
                    for (int i = 0; i < n; i++) begin
                        b = pick_bone();
                        add_infl(b, rand_weight(), k, rand_q(), rand_q(), rand_q(), i == n-1);
                    end
                end
            endcase
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_items.size() == 0 && !i_in_valid && skinned_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && skinned_q.size() == 0) begin
            $display("linear_blend_skinning_core_tb: done, clean");
        end else begin
            $display("linear_blend_skinning_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== linear_blend_skinning_core.f =====
rtl/lbs_pkg.sv
rtl/lbs_ctrl.sv
rtl/lbs_dp.sv
rtl/linear_blend_skinning_core.sv
rtl/lbs_checker.sv
tb/linear_blend_skinning_core_tb.sv
